/* hdl/mxpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mxpt_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 31;
    localparam int NODE_SLOTS = 2048;

    localparam int OUT_W      = 31;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(NODE_SLOTS);
    localparam int NODES_W    = $clog2(NODE_SLOTS + 1);
    localparam int ITEMS_W    = $clog2(MAX_ITEMS + 1);
    localparam int LVL_W      = $clog2(VALUE_BITS);
    localparam int NODE_LIMIT = NODE_SLOTS - VALUE_BITS;

    typedef logic [VALUE_BITS-1:0]     t_value;
    typedef logic [OUT_W-1:0]          t_max;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [1:0][IDX_W-1:0]     t_row;
    typedef logic [NODES_W-1:0]        t_nodes;
    typedef logic [ITEMS_W-1:0]        t_items;
    typedef logic [LVL_W-1:0]          t_lvl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_UPDATE,
        ST_INSERT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/max_xor_pair_trie.sv */
// Largest XOR of any two values of a set. Send the values one transaction
// each on the slave stream, tlast on the final one; that transaction returns
// one result (max_xor, overflowed) on the master stream and clears the set.
// Each value is taken one bit per cycle through a binary trie held in a
// single-port-read memory, one trie level per cycle: ST_QUERY walks the trie
// to query, ST_UPDATE keeps the best, ST_INSERT walks it again to insert; the
// first value of a set has no query walk, and a value dropped beyond capacity
// takes no walk; the final value passes ST_EMIT to load the result register.
// A new value is taken while an earlier result waits on the master side. Node
// storage is tracked by a fill count, so reset and clearing take no sweep.
`timescale 1ns / 1ps
`default_nettype none

module max_xor_pair_trie (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  wire  [mxpt_pkg::DATA_W-1:0] i_s_tdata,   // [30:0] value, [31] zero
    input  wire                         i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [mxpt_pkg::DATA_W-1:0] o_m_tdata,   // [30:0] max_xor, [31] zero
    output logic                        o_m_tuser    // overflowed
);

    import mxpt_pkg::*;

    t_state r_state,     n_state;
    t_value r_val,       n_val;
    t_value r_acc,       n_acc;
    t_idx   r_cur,       n_cur;
    t_lvl   r_lvl,       n_lvl;
    logic   r_fresh,     n_fresh;
    logic   r_last,      n_last;
    t_nodes r_nodes,     n_nodes;
    t_items r_items,     n_items;
    t_max   r_best,      n_best;
    logic   r_dropped,   n_dropped;
    t_row   r_root,      n_root;
    logic   r_out_valid, n_out_valid;
    t_max   r_out_max,   n_out_max;
    logic   r_out_ovf,   n_out_ovf;
    t_row   r_rd;

    t_row   mem [NODE_SLOTS];

    t_row   row;
    t_row   wr_row;
    t_idx   other;
    t_idx   same;
    t_idx   nxt;
    t_idx   rd_addr;
    logic   bit_b;
    logic   mem_we;
    logic   full;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_W'(r_out_max);
    assign o_m_tuser  = r_out_ovf;

    always_comb begin
        row = (r_cur == '0) ? r_root : r_rd;
        if (r_fresh) begin
            row = '0;
        end
        bit_b  = r_val[VALUE_BITS-1];
        other  = row[~bit_b];
        same   = row[bit_b];
        wr_row = row;
        wr_row[bit_b] = r_nodes[IDX_W-1:0];
        full   = (r_items >= ITEMS_W'(MAX_ITEMS)) || (r_nodes > NODES_W'(NODE_LIMIT));
        nxt    = same;
        mem_we = 1'b0;

        n_state     = r_state;
        n_val       = r_val;
        n_acc       = r_acc;
        n_cur       = r_cur;
        n_lvl       = r_lvl;
        n_fresh     = r_fresh;
        n_last      = r_last;
        n_nodes     = r_nodes;
        n_items     = r_items;
        n_best      = r_best;
        n_dropped   = r_dropped;
        n_root      = r_root;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_max   = r_out_max;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_last  = i_s_tlast;
                    n_val   = t_value'(i_s_tdata[OUT_W-1:0]);
                    n_acc   = '0;
                    n_cur   = '0;
                    n_lvl   = LVL_W'(VALUE_BITS - 1);
                    n_fresh = 1'b0;
                    if (full) begin
                        n_dropped = 1'b1;
                        n_state   = i_s_tlast ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_items = r_items + 1'b1;
                        n_state = (r_items != '0) ? ST_QUERY : ST_INSERT;
                    end
                end
            end
            ST_QUERY: begin
                nxt   = (other != '0) ? other : same;
                n_acc = {r_acc[VALUE_BITS-2:0], other != '0};
                n_cur = nxt;
                n_val = {r_val[VALUE_BITS-2:0], r_val[VALUE_BITS-1]};
                if (r_lvl == '0) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            ST_UPDATE: begin
                if (t_max'(r_acc) > r_best) begin
                    n_best = t_max'(r_acc);
                end
                n_cur   = '0;
                n_lvl   = LVL_W'(VALUE_BITS - 1);
                n_fresh = 1'b0;
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                if (!r_fresh && same != '0) begin
                    nxt = same;
                end else begin
                    nxt     = r_nodes[IDX_W-1:0];
                    n_nodes = r_nodes + 1'b1;
                    n_fresh = 1'b1;
                    if (r_cur == '0) begin
                        n_root = wr_row;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                n_cur = nxt;
                n_val = {r_val[VALUE_BITS-2:0], r_val[VALUE_BITS-1]};
                if (r_lvl == '0) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_best;
                    n_out_ovf   = r_dropped;
                    n_root      = '0;
                    n_nodes     = NODES_W'(1);
                    n_best      = '0;
                    n_items     = '0;
                    n_dropped   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        rd_addr = n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fresh     <= 1'b0;
            r_last      <= 1'b0;
            r_nodes     <= NODES_W'(1);
            r_items     <= '0;
            r_best      <= '0;
            r_dropped   <= 1'b0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_last      <= n_last;
            r_nodes     <= n_nodes;
            r_items     <= n_items;
            r_best      <= n_best;
            r_dropped   <= n_dropped;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_acc     <= n_acc;
        r_cur     <= n_cur;
        r_lvl     <= n_lvl;
        r_out_max <= n_out_max;
        r_out_ovf <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cur] <= wr_row;
        end
        r_rd <= mem[rd_addr];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes <= NODES_W'(NODE_SLOTS))
        else $error("node count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items <= ITEMS_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_cur != '0) && (r_state == ST_INSERT))
        else $error("node write outside insert walk or at root");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result loaded outside emit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUERY) |-> !r_fresh && (r_items > ITEMS_W'(1)))
        else $error("query walk on fresh path or single-value set");

endmodule

`default_nettype wire
